// ===== rtl/swma_pkg.sv =====
// ----------------------------------------------------------------------------
// swma_pkg
// Shared types and constants of the sorted-window median block.
// ----------------------------------------------------------------------------
`default_nettype none

package swma_pkg;

    localparam int ANGLE_W         = 9;
    localparam int LIMIT_W         = 8;
    localparam int WINDOW_SIZE_DEF = 50;
    localparam logic [LIMIT_W-1:0] MISS_LIMIT_RST = 8'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PLACE,
        S_MED_LO,
        S_MED_HI,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_top;
        logic rd_lo;
        logic rd_hi;
        logic lo_latch;
        logic wr_shift;
        logic wr_angle_ptr;
        logic wr_angle_zero;
        logic median;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic less;
        logic ptr_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/swma_ram.sv =====
// ----------------------------------------------------------------------------
// swma_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_ram #(
    parameter  int WIDTH = 9,
    parameter  int DEPTH = 50,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/swma_dp.sv =====
// ----------------------------------------------------------------------------
// swma_dp
// Datapath: sorted table RAM, fill and miss counters, median arithmetic,
// flags and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_dp #(
    parameter  int WINDOW_SIZE = swma_pkg::WINDOW_SIZE_DEF,
    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1,
    localparam int CW = $clog2(WINDOW_SIZE + 1)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire swma_pkg::t_cmd                       i_cmd,
    output swma_pkg::t_status                         o_status,
    input  wire logic                                 i_meas_valid,
    input  wire logic signed [swma_pkg::ANGLE_W-1:0]  i_meas_angle,
    input  wire logic                                 i_read_ack,
    input  wire logic                                 i_cfg_valid,
    input  wire logic        [swma_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic             [swma_pkg::ANGLE_W-1:0]  o_median_angle,
    output logic                                      o_median_valid,
    output logic                                      o_median_fresh
);
    import swma_pkg::*;

    localparam logic [AW-1:0] LO_ADDR = AW'(WINDOW_SIZE / 2 - 1);
    localparam logic [AW-1:0] HI_ADDR = AW'(WINDOW_SIZE / 2);

    logic        [CW-1:0]      r_fill;
    logic        [LIMIT_W-1:0] r_miss;
    logic        [LIMIT_W-1:0] r_limit;
    logic signed [ANGLE_W-1:0] r_median;
    logic                      r_valid;
    logic                      r_fresh;
    logic signed [ANGLE_W-1:0] r_angle;
    logic        [AW-1:0]      r_ptr;
    logic signed [ANGLE_W-1:0] r_lo;
    logic                      r_ovalid;
    logic        [ANGLE_W-1:0] r_oangle;
    logic                      r_ovld;
    logic                      r_ofresh;

    logic                      ram_we;
    logic        [AW-1:0]      ram_waddr;
    logic signed [ANGLE_W-1:0] ram_wdata;
    logic                      ram_re;
    logic        [AW-1:0]      ram_raddr;
    logic signed [ANGLE_W-1:0] ram_rdata;
    logic        [CW-1:0]      fill_m1;
    logic signed [ANGLE_W:0]   sum;
    logic signed [ANGLE_W:0]   sum_adj;
    logic                      ptr_zero;

    swma_ram #(
        .WIDTH (ANGLE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        fill_m1   = r_fill - CW'(1);
        ptr_zero  = (r_ptr == '0);
        ram_we    = i_cmd.wr_shift | i_cmd.wr_angle_ptr | i_cmd.wr_angle_zero;
        ram_waddr = i_cmd.wr_angle_zero ? '0 : r_ptr + AW'(1);
        ram_wdata = i_cmd.wr_shift ? ram_rdata : r_angle;
        ram_re    = i_cmd.rd_top | i_cmd.rd_lo | i_cmd.rd_hi | (i_cmd.wr_shift & ~ptr_zero);
        if (i_cmd.rd_top) begin
            ram_raddr = fill_m1[AW-1:0];
        end else if (i_cmd.rd_lo) begin
            ram_raddr = LO_ADDR;
        end else if (i_cmd.rd_hi) begin
            ram_raddr = HI_ADDR;
        end else begin
            ram_raddr = r_ptr - AW'(1);
        end
        // mean of the two middle entries, truncated toward zero
        sum     = {r_lo[ANGLE_W-1], r_lo} + {ram_rdata[ANGLE_W-1], ram_rdata};
        sum_adj = sum + {{ANGLE_W{1'b0}}, sum[ANGLE_W]};

        o_status.full     = (r_fill >= CW'(WINDOW_SIZE));
        o_status.empty    = (r_fill == '0);
        o_status.less     = (r_angle < ram_rdata);
        o_status.ptr_zero = ptr_zero;
        o_status.out_free = ~r_ovalid | i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_miss   <= '0;
            r_limit  <= MISS_LIMIT_RST;
            r_median <= '0;
            r_valid  <= 1'b0;
            r_fresh  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (i_read_ack) begin
                    r_fresh <= 1'b0;
                end
                if (i_meas_valid) begin
                    r_miss <= '0;
                end else if (r_miss >= r_limit) begin
                    r_miss  <= '0;
                    r_fill  <= '0;
                    r_valid <= 1'b0;
                    r_fresh <= 1'b0;
                end else begin
                    r_miss <= r_miss + LIMIT_W'(1);
                end
            end
            if (i_cmd.wr_angle_ptr | i_cmd.wr_angle_zero) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.median) begin
                r_median <= sum_adj[ANGLE_W:1];
                r_valid  <= 1'b1;
                r_fresh  <= 1'b1;
                r_fill   <= '0;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_angle <= i_meas_angle;
        end
        if (i_cmd.rd_top) begin
            r_ptr <= fill_m1[AW-1:0];
        end else if (i_cmd.wr_shift) begin
            r_ptr <= r_ptr - AW'(1);
        end
        if (i_cmd.lo_latch) begin
            r_lo <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_oangle <= r_median;
            r_ovld   <= r_valid;
            r_ofresh <= r_fresh;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_median_angle = r_oangle;
    assign o_median_valid = r_ovld;
    assign o_median_fresh = r_ofresh;

endmodule

`default_nettype wire

// ===== rtl/swma_ctrl.sv =====
// ----------------------------------------------------------------------------
// swma_ctrl
// Controller: sequences the insertion walk, the median read and the
// hand-over to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swma_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_meas_valid,
    output logic                   o_in_ready,
    input  wire swma_pkg::t_status i_status,
    output swma_pkg::t_cmd         o_cmd
);
    import swma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_meas_valid) begin
                        n_state = S_OUT;
                    end else if (i_status.full) begin
                        o_cmd.rd_lo = 1'b1;
                        n_state     = S_MED_LO;
                    end else if (i_status.empty) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_top = 1'b1;
                        n_state      = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (i_status.less) begin
                    o_cmd.wr_shift = 1'b1;
                    if (i_status.ptr_zero) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    o_cmd.wr_angle_ptr = 1'b1;
                    n_state            = S_OUT;
                end
            end
            S_PLACE: begin
                o_cmd.wr_angle_zero = 1'b1;
                n_state             = S_OUT;
            end
            S_MED_LO: begin
                o_cmd.lo_latch = 1'b1;
                o_cmd.rd_hi    = 1'b1;
                n_state        = S_MED_HI;
            end
            S_MED_HI: begin
                o_cmd.median = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_window_median_angle.sv =====
// ----------------------------------------------------------------------------
// sorted_window_median_angle
// Median of a window of direction measurements, kept sorted by insertion.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. An invalid measurement goes straight to
// the output register, a measurement into a full table reads the two middle
// entries for the median, and in an insertion the new angle walks the sorted
// table from the top down, one entry per cycle, bound by the single read and
// single write port of the table RAM. The next beat is taken while the
// previous result still waits in the output register.
`default_nettype none

module sorted_window_median_angle #(
    parameter int WINDOW_SIZE = swma_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [15:0]                    i_s_axis_tdata,  // meas_angle, read_ack
    input  wire logic                           i_s_axis_tuser,  // meas_valid
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic      [15:0]                    o_m_axis_tdata,  // median_angle
    output logic      [1:0]                     o_m_axis_tuser,  // median_valid, median_fresh
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [swma_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import swma_pkg::*;

    t_cmd                cmd;
    t_status             status;
    logic [ANGLE_W-1:0]  median_angle;
    logic                median_valid;
    logic                median_fresh;

    swma_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_meas_valid (i_s_axis_tuser),
        .o_in_ready   (o_s_axis_tready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    swma_dp #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_meas_valid   (i_s_axis_tuser),
        .i_meas_angle   (i_s_axis_tdata[ANGLE_W-1:0]),
        .i_read_ack     (i_s_axis_tdata[ANGLE_W]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_median_angle (median_angle),
        .o_median_valid (median_valid),
        .o_median_fresh (median_fresh)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {{(16 - ANGLE_W){1'b0}}, median_angle};
    assign o_m_axis_tuser = {median_fresh, median_valid};

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_shift, cmd.wr_angle_ptr, cmd.wr_angle_zero}))
        else $error("more than one table write in a cycle");

    a_median_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.median |=> status.empty)
        else $error("table not emptied after median");

    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.wr_angle_ptr || cmd.wr_angle_zero) |=> !status.empty)
        else $error("table empty after insertion");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("output register overwritten before taken");

endmodule

`default_nettype wire

// ===== dv/sorted_window_median_angle_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_window_median_angle_tb
// Self-checking bench for the sorted-window median block. Measurement beats
// are sent with random gaps and the result stream is stalled at random. Each
// accepted measurement runs through a local window/median predictor, and every
// result beat is checked field by field against the oldest prediction. The
// miss limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_window_median_angle_tb;

    import swma_pkg::*;

    localparam int WIN        = WINDOW_SIZE_DEF;
    localparam int SETTLE_CYC = WIN + 8;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               valid;
        logic               fresh;
    } median_beat_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [15:0]         s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [LIMIT_W-1:0]  cfg_data = '0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [15:0]         m_tdata;
    wire  [1:0]          m_tuser;
    wire                 cfg_ready;

    // window predictor state
    logic signed [ANGLE_W-1:0] win_sorted [0:WIN-1];
    int                        win_fill;
    int                        miss_run;
    logic [LIMIT_W-1:0]        miss_limit_shadow;
    logic signed [ANGLE_W-1:0] median_hold;
    bit                        valid_hold;
    bit                        fresh_hold;

    median_beat_t pending_medians [$];

    int  errors       = 0;
    int  frames_sent  = 0;
    int  beats_seen   = 0;
    int  medians_made = 0;
    int  discards     = 0;
    int  limits_used  = 0;
    bit  src_idle     = 1'b1;
    bit  sink_idle    = 1'b1;
    int  sink_hold    = 0;

    sorted_window_median_angle dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // meas_angle, read_ack
        .i_s_axis_tuser  (s_tuser),   // meas_valid
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // median_angle
        .o_m_axis_tuser  (m_tuser),   // median_valid, median_fresh
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic clear_window_model();
        win_fill          = 0;
        miss_run          = 0;
        miss_limit_shadow = MISS_LIMIT_RST;
        median_hold       = '0;
        valid_hold        = 1'b0;
        fresh_hold        = 1'b0;
        for (int i = 0; i < WIN; i++) win_sorted[i] = '0;
    endtask

    task automatic predict_frame(input bit valid, input logic signed [ANGLE_W-1:0] angle,
                                 input bit ack);
        int           pos;
        int           mean;
        bit           found;
        median_beat_t beat;
        if (ack) fresh_hold = 1'b0;
        if (valid) begin
            if (win_fill >= WIN) begin
                mean        = (int'(win_sorted[WIN/2-1]) + int'(win_sorted[WIN/2])) / 2;
                median_hold = mean[ANGLE_W-1:0];
                valid_hold  = 1'b1;
                fresh_hold  = 1'b1;
                win_fill    = 0;
                medians_made++;
            end else begin
                // equal angles go after the existing ones
                pos   = win_fill;
                found = 1'b0;
                for (int i = 0; i < win_fill; i++) begin
                    if (!found && angle < win_sorted[i]) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = win_fill; i > pos; i--) win_sorted[i] = win_sorted[i-1];
                win_sorted[pos] = angle;
                win_fill++;
            end
            miss_run = 0;
        end else if (miss_run >= miss_limit_shadow) begin
            miss_run   = 0;
            win_fill   = 0;
            valid_hold = 1'b0;
            fresh_hold = 1'b0;
            discards++;
        end else begin
            miss_run++;
        end
        beat.angle = median_hold;
        beat.valid = valid_hold;
        beat.fresh = fresh_hold;
        pending_medians.push_back(beat);
    endtask

    task automatic send_frame(input bit valid, input int angle, input bit ack);
        int                        gap;
        logic signed [ANGLE_W-1:0] a9;
        a9  = angle[ANGLE_W-1:0];
        gap = src_idle ? int'($urandom_range(0, 17)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ack, a9};
        s_tuser  <= valid;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_frame(valid, a9, ack);
        frames_sent++;
    endtask

    // sender pauses until every predicted beat is back, then lets the block settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_miss_limit(input int limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit[LIMIT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        miss_limit_shadow = limit[LIMIT_W-1:0];
        limits_used++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one well-formed window: WIN valid angles plus the median trigger, with
    // invalid bursts no longer than max_burst in between
    task automatic send_window(input int lo, input int hi, input int max_burst,
                               input int burst_pct);
        int burst;
        for (int n = 0; n <= WIN; n++) begin
            if (max_burst > 0 && rand_between(0, 99) < burst_pct) begin
                burst = rand_between(1, max_burst);
                repeat (burst) send_frame(1'b0, rand_between(-180, 180), $urandom_range(0, 3) == 0);
            end
            send_frame(1'b1, rand_between(lo, hi), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_miss_default();
        // reset limit: five misses tolerated, the sixth discards
        for (int i = 0; i < 6; i++) send_frame(1'b0, (i % 2) ? 180 : -180, i[0]);
        send_frame(1'b1, -180, 1'b0);
        send_frame(1'b1, 180, 1'b1);
        send_frame(1'b1, 0, 1'b1);
        wait_quiet();
    endtask

    task automatic test_limit_extremes();
        write_miss_limit(0);
        send_frame(1'b0, 17, 1'b0);
        send_frame(1'b1, 180, 1'b0);
        send_frame(1'b0, -1, 1'b1);
        send_frame(1'b0, -180, 1'b0);
        wait_quiet();
        write_miss_limit(255);
    endtask

    task automatic test_extreme_windows();
        send_window(-180, -180, 0, 0);
        send_window(180, 180, 0, 0);
        // half each extreme: middle pair straddles the two
        for (int n = 0; n <= WIN; n++) send_frame(1'b1, (n % 2) ? 180 : -180, 1'b0);
        // middle pair -3 and 0: mean truncates towards zero
        for (int n = 0; n <= WIN; n++) send_frame(1'b1, (n < WIN / 2) ? -3 : 0, n == WIN);
        send_frame(1'b0, 5, 1'b1);
        wait_quiet();
    endtask

    task automatic test_limit_lowered();
        send_window(-90, 90, 4, 20);
        for (int i = 0; i < 6; i++) send_frame(1'b0, rand_between(-180, 180), 1'b0);
        wait_quiet();
        write_miss_limit(2);
        send_frame(1'b0, 0, 1'b0);
        send_frame(1'b1, 42, 1'b0);
        wait_quiet();
    endtask

    task automatic test_output_hold();
        src_idle  = 1'b0;
        sink_hold = 400;
        for (int i = 0; i < 40; i++) send_frame($urandom_range(0, 4) != 0,
                                                rand_between(-180, 180),
                                                $urandom_range(0, 1));
        wait_quiet();
        src_idle = 1'b1;
    endtask

    task automatic test_random_windows(input int target);
        int limit;
        int pick;
        int base;
        int len;
        int stop_at;
        stop_at = frames_sent + target;
        while (frames_sent < stop_at) begin
            wait_quiet();
            case ($urandom_range(0, 5))
                0: limit = 0;
                1: limit = 1;
                2: limit = 3;
                3: limit = 255;
                4: limit = 5;
                default: limit = rand_between(0, 255);
            endcase
            write_miss_limit(limit);
            repeat (rand_between(2, 5)) begin
                src_idle  = $urandom_range(0, 4) != 0;
                sink_idle = $urandom_range(0, 4) != 0;
                pick      = rand_between(0, 9);
                if (pick < 8) begin
                    base = rand_between(-180, 180);
                    case ($urandom_range(0, 3))
                        0: send_window(-180, 180, (limit < 6) ? limit : 6, 15);
                        1: send_window((base < 170) ? base : 170,
                                       (base < 170) ? base + 10 : 180,
                                       (limit < 3) ? limit : 3, 10);
                        2: send_window(-180, 180, 0, 0);
                        default: send_window(-20, 20, (limit < 2) ? limit : 2, 25);
                    endcase
                end else begin
                    // noise, partial windows and over-long miss runs
                    len = rand_between(5, 40);
                    repeat (len) send_frame($urandom_range(0, 1), rand_between(-180, 180),
                                            $urandom_range(0, 1));
                    if (limit < 8)
                        repeat (limit + rand_between(1, 3))
                            send_frame(1'b0, rand_between(-180, 180), 1'b0);
                end
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        wait_quiet();
    endtask

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        int stall;
        forever begin
            stall = sink_idle ? int'($urandom_range(0, 17)) : 0;
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk) begin : check_beat
        median_beat_t want;
        if (rst_n && m_tvalid && m_tready) begin
            beats_seen++;
            if (pending_medians.size() == 0) begin
                errors++;
                if (errors < 50)
                    $display("%0t: unexpected result beat, angle %0d valid %0b fresh %0b",
                             $time, $signed(m_tdata[ANGLE_W-1:0]), m_tuser[0], m_tuser[1]);
            end else begin
                want = pending_medians.pop_front();
                if (m_tdata[ANGLE_W-1:0] !== want.angle) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: median_angle expected %0d got %0d", $time,
                                 $signed(want.angle), $signed(m_tdata[ANGLE_W-1:0]));
                end
                if (m_tuser[0] !== want.valid) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: median_valid expected %0b got %0b", $time,
                                 want.valid, m_tuser[0]);
                end
                if (m_tuser[1] !== want.fresh) begin
                    errors++;
                    if (errors < 50)
                        $display("%0t: median_fresh expected %0b got %0b", $time,
                                 want.fresh, m_tuser[1]);
                end
            end
        end
    end

    initial begin
        clear_window_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_miss_default();
        test_limit_extremes();
        test_extreme_windows();
        test_limit_lowered();
        write_miss_limit(255);
        test_output_hold();
        test_random_windows(1650);

        $display("Covered %0d measurement beats, %0d result beats, %0d medians, %0d discards",
                 frames_sent, beats_seen, medians_made, discards);
        $display("Miss limit written %0d times, including 0 and 255", limits_used);
        if (errors == 0 && pending_medians.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
